// ----- hw/rtl/round_robin_task_timer_top_macros.svh -----
// Assertion macros for the round-robin task timer.
`ifndef ROUND_ROBIN_TASK_TIMER_TOP_MACROS_SVH
`define ROUND_ROBIN_TASK_TIMER_TOP_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RRTT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define RRTT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/rrtt_pkg.sv -----
// Shared types and constants of the round-robin task timer.
package rrtt_pkg;

    localparam int RRTT_NUM_TASKS  = 4;
    localparam int RRTT_DELAY_BITS = 16;

    localparam int KIND_W = 3;
    localparam int IDX_IN_W = 3;
    localparam int LOAD_W = 16;
    localparam int CFG_W = 3;
    localparam int RUN_TASK_W = 2;

    localparam logic [CFG_W-1:0] TASK_COUNT_RST = 3'd4;

    localparam logic [KIND_W-1:0] K_TICK    = 3'd0;
    localparam logic [KIND_W-1:0] K_POLL    = 3'd1;
    localparam logic [KIND_W-1:0] K_ENABLE  = 3'd2;
    localparam logic [KIND_W-1:0] K_DISABLE = 3'd3;
    localparam logic [KIND_W-1:0] K_LOAD    = 3'd4;

    typedef struct packed {
        logic load_item;
        logic tick_step;
        logic exec_op;
        logic push_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic sweep_last;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- hw/rtl/rrtt_ctrl.sv -----
// Controller state machine of the round-robin task timer.
module rrtt_ctrl
    import rrtt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WORK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state = S_WORK;
                end
            end
            S_WORK: begin
                if (i_sts.is_tick) begin
                    o_cmd.tick_step = 1'b1;
                    if (i_sts.sweep_last) begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd.exec_op = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.push_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;

endmodule

// ----- hw/rtl/rrtt_dp.sv -----
// Datapath of the round-robin task timer: task table, pointer, result register.
module rrtt_dp
    import rrtt_pkg::*;
#(
    parameter int NUM_TASKS  = RRTT_NUM_TASKS,
    parameter int DELAY_BITS = RRTT_DELAY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [IDX_IN_W-1:0]   i_task_index,
    input  logic [LOAD_W-1:0]     i_load_period,
    input  logic [LOAD_W-1:0]     i_load_delay,
    input  logic                  i_out_stall,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    output logic                  o_out_valid,
    output logic                  o_run_valid,
    output logic [RUN_TASK_W-1:0] o_run_task,
    output logic                  o_index_ignored
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam int CMP_W = CNT_W + IDX_IN_W + 1;

    logic [CFG_W-1:0]      r_task_count;
    logic [KIND_W-1:0]     r_kind;
    logic [IDX_IN_W-1:0]   r_idx;
    logic [DELAY_BITS-1:0] r_ld_period;
    logic [DELAY_BITS-1:0] r_ld_delay;
    logic [IDX_W-1:0]      r_sweep;
    logic [IDX_W-1:0]      r_ptr;
    logic [DELAY_BITS-1:0] r_delay  [NUM_TASKS];
    logic [DELAY_BITS-1:0] r_period [NUM_TASKS];
    logic [NUM_TASKS-1:0]  r_ready;
    logic                  r_res_run;
    logic [RUN_TASK_W-1:0] r_res_task;
    logic                  r_res_ign;
    logic                  r_out_valid;
    logic                  r_out_run;
    logic [RUN_TASK_W-1:0] r_out_task;
    logic                  r_out_ign;

    logic [DELAY_BITS+LOAD_W-1:0] ld_period_x;
    logic [DELAY_BITS+LOAD_W-1:0] ld_delay_x;
    logic [CMP_W-1:0]      tc_x;
    logic [CMP_W-1:0]      eff;
    logic [CMP_W-1:0]      idx_x;
    logic [CMP_W-1:0]      ptr_x;
    logic [CMP_W-1:0]      sweep_x;
    logic                  idx_out;
    logic                  ptr_out;
    logic                  ptr_wrap;
    logic [IDX_W-1:0]      addr;
    logic [DELAY_BITS-1:0] rd_delay;
    logic                  due;

    assign ld_period_x = {{DELAY_BITS{1'b0}}, i_load_period};
    assign ld_delay_x  = {{DELAY_BITS{1'b0}}, i_load_delay};

    assign tc_x    = {{(CMP_W-CFG_W){1'b0}}, r_task_count};
    assign idx_x   = {{(CMP_W-IDX_IN_W){1'b0}}, r_idx};
    assign ptr_x   = {{(CMP_W-IDX_W){1'b0}}, r_ptr};
    assign sweep_x = {{(CMP_W-IDX_W){1'b0}}, r_sweep};

    always_comb begin
        priority if (r_task_count == '0) begin
            eff = CMP_W'(1);
        end else if (tc_x > CMP_W'(NUM_TASKS)) begin
            eff = CMP_W'(NUM_TASKS);
        end else begin
            eff = tc_x;
        end
    end

    assign idx_out  = (idx_x >= eff);
    assign ptr_out  = (ptr_x >= eff);
    assign ptr_wrap = ((ptr_x + CMP_W'(1)) == eff);

    // one table port, shared by sweep, poll and the indexed commands
    always_comb begin
        priority if (r_kind == K_TICK) begin
            addr = r_sweep;
        end else if (r_kind == K_POLL) begin
            addr = r_ptr;
        end else begin
            addr = idx_x[IDX_W-1:0];
        end
    end

    assign rd_delay = r_delay[addr];
    assign due      = (rd_delay == '0) && r_ready[addr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= TASK_COUNT_RST;
        end else if (i_cfg_we) begin
            r_task_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind      <= i_kind;
            r_idx       <= i_task_index;
            r_ld_period <= ld_period_x[DELAY_BITS-1:0];
            r_ld_delay  <= ld_delay_x[DELAY_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_sweep <= '0;
        end else if (i_cmd.tick_step) begin
            r_sweep <= r_sweep + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_cmd.exec_op && (r_kind == K_POLL)) begin
            if (ptr_out || ptr_wrap) begin
                r_ptr <= '0;
            end else begin
                r_ptr <= r_ptr + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TASKS; k++) begin
                r_delay[k]  <= '0;
                r_period[k] <= '0;
            end
            r_ready <= '1;
        end else if (i_cmd.tick_step) begin
            if (rd_delay != '0) begin
                r_delay[addr] <= rd_delay - DELAY_BITS'(1);
            end
        end else if (i_cmd.exec_op) begin
            unique case (r_kind)
                K_POLL: begin
                    if (!ptr_out && due) begin
                        r_delay[addr] <= r_period[addr];
                    end
                end
                K_ENABLE: begin
                    if (!idx_out) begin
                        r_ready[addr] <= 1'b1;
                    end
                end
                K_DISABLE: begin
                    if (!idx_out) begin
                        r_ready[addr] <= 1'b0;
                    end
                end
                K_LOAD: begin
                    if (!idx_out) begin
                        r_period[addr] <= r_ld_period;
                        r_delay[addr]  <= r_ld_delay;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_res_run  <= 1'b0;
            r_res_task <= '0;
            r_res_ign  <= 1'b0;
        end else if (i_cmd.exec_op) begin
            unique case (r_kind)
                K_POLL: begin
                    r_res_run  <= !ptr_out && due;
                    r_res_task <= ptr_x[RUN_TASK_W-1:0];
                end
                K_ENABLE, K_DISABLE, K_LOAD: begin
                    r_res_ign <= idx_out;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_out) begin
            r_out_run  <= r_res_run;
            r_out_task <= r_res_task;
            r_out_ign  <= r_res_ign;
        end
    end

    assign o_sts.is_tick    = (r_kind == K_TICK);
    assign o_sts.sweep_last = ((sweep_x + CMP_W'(1)) == eff);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_run_valid     = r_out_run;
    assign o_run_task      = r_out_task;
    assign o_index_ignored = r_out_ign;

endmodule

// ----- hw/rtl/round_robin_task_timer_top.sv -----
// Top level of the round-robin task timer.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------
//  input    | i_in_valid / o_in_stall  | i_kind i_task_index i_load_period i_load_delay
//  output   | o_out_valid / i_out_stall| o_run_valid o_run_task o_index_ignored
//  config   | i_cfg_we                 | i_cfg_wdata (task_count)
//
// A tick walks the tasks in use with one shared decrementer, one entry per cycle.
// One item is in work at a time; a new one is taken while the result waits.
// Reset (synchronous, active low) clears the task table, sets all tasks ready
// and sets task_count to 4; the input is stalled while reset is held.
// A stalled output holds the next finished result, and with it the input.
module round_robin_task_timer_top
    import rrtt_pkg::*;
#(
    parameter int NUM_TASKS  = RRTT_NUM_TASKS,
    parameter int DELAY_BITS = RRTT_DELAY_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [IDX_IN_W-1:0]   i_task_index,
    input  logic [LOAD_W-1:0]     i_load_period,
    input  logic [LOAD_W-1:0]     i_load_delay,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_run_valid,
    output logic [RUN_TASK_W-1:0] o_run_task,
    output logic                  o_index_ignored
);

`include "round_robin_task_timer_top_macros.svh"

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;

    rrtt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    rrtt_dp #(
        .NUM_TASKS  (NUM_TASKS),
        .DELAY_BITS (DELAY_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_kind          (i_kind),
        .i_task_index    (i_task_index),
        .i_load_period   (i_load_period),
        .i_load_delay    (i_load_delay),
        .i_out_stall     (i_out_stall),
        .i_cmd           (s_cmd),
        .o_sts           (s_sts),
        .o_out_valid     (o_out_valid),
        .o_run_valid     (o_run_valid),
        .o_run_task      (o_run_task),
        .o_index_ignored (o_index_ignored)
    );

    `RRTT_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `RRTT_ASSERT_NEXT(a_push_sets_valid, s_cmd.push_out, o_out_valid)
    `RRTT_ASSERT_NOW(a_run_xor_ignored, o_out_valid && o_run_valid, !o_index_ignored)

endmodule

// ----- tb/round_robin_task_timer_top_tb.sv -----
// Self-checking testbench for the round-robin task timer: directed and random transactions.
`timescale 1ns / 100ps

module round_robin_task_timer_top_tb
    import rrtt_pkg::*;
();

    localparam int NUM_TASKS  = RRTT_NUM_TASKS;
    localparam int DELAY_BITS = RRTT_DELAY_BITS;

    localparam logic [KIND_W-1:0] K_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] K_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE_C = 3'd7;

    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES    = 12;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [IDX_IN_W-1:0] idx;
        logic [LOAD_W-1:0]   period;
        logic [LOAD_W-1:0]   delay;
    } t_sched_op;

    typedef struct packed {
        logic                  run_valid;
        logic [RUN_TASK_W-1:0] run_task;
        logic                  ignored;
    } t_sched_result;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  in_valid;
    logic                  in_stall;
    logic [KIND_W-1:0]     kind;
    logic [IDX_IN_W-1:0]   task_index;
    logic [LOAD_W-1:0]     load_period;
    logic [LOAD_W-1:0]     load_delay;
    logic                  out_valid;
    logic                  out_stall;
    logic                  run_valid;
    logic [RUN_TASK_W-1:0] run_task;
    logic                  index_ignored;

    round_robin_task_timer_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_kind          (kind),
        .i_task_index    (task_index),
        .i_load_period   (load_period),
        .i_load_delay    (load_delay),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_run_valid     (run_valid),
        .o_run_task      (run_task),
        .o_index_ignored (index_ignored)
    );

    // Scheduler shadow state
    logic [CFG_W-1:0]      pred_task_count;
    logic [DELAY_BITS-1:0] pred_delay  [NUM_TASKS];
    logic [DELAY_BITS-1:0] pred_period [NUM_TASKS];
    logic                  pred_ready  [NUM_TASKS];
    logic [1:0]            pred_ptr;

    t_sched_op     pending_ops[$];
    t_sched_result expected_runs[$];
    t_sched_result want;
    t_sched_op     next_op;

    int  failures = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  stall_left = 0;
    bit  long_hold_go = 0;
    bit  long_hold_done = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int active_tasks();
        if (pred_task_count == 0) return 1;
        if (pred_task_count > NUM_TASKS) return NUM_TASKS;
        return int'(pred_task_count);
    endfunction

    function automatic t_sched_result timer_step(t_sched_op op);
        t_sched_result r;
        int cnt;
        r = '0;
        cnt = active_tasks();
        case (op.kind)
            K_TICK: begin
                for (int i = 0; i < cnt; i++)
                    if (pred_delay[i] != 0) pred_delay[i] = pred_delay[i] - 1'b1;
            end
            K_POLL: begin
                r.run_task = pred_ptr;
                if (pred_ptr >= cnt) begin
                    pred_ptr = '0;
                end else begin
                    if (pred_delay[pred_ptr] == 0 && pred_ready[pred_ptr]) begin
                        r.run_valid = 1'b1;
                        pred_delay[pred_ptr] = pred_period[pred_ptr];
                    end
                    pred_ptr = 2'((int'(pred_ptr) + 1) % cnt);
                end
            end
            K_ENABLE, K_DISABLE, K_LOAD: begin
                if (op.idx >= cnt) begin
                    r.ignored = 1'b1;
                end else if (op.kind == K_ENABLE) begin
                    pred_ready[op.idx] = 1'b1;
                end else if (op.kind == K_DISABLE) begin
                    pred_ready[op.idx] = 1'b0;
                end else begin
                    pred_period[op.idx] = op.period;
                    pred_delay[op.idx]  = op.delay;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_sched_op make_op(logic [KIND_W-1:0] k, int idx, int per, int dly);
        t_sched_op op;
        op.kind   = k;
        op.idx    = IDX_IN_W'(idx);
        op.period = LOAD_W'(per);
        op.delay  = LOAD_W'(dly);
        return op;
    endfunction

    // Mostly well-formed scheduling traffic: small periods so tasks fall due often.
    function automatic t_sched_op random_op();
        t_sched_op op;
        int r;
        int cnt;
        cnt = active_tasks();
        r = $urandom_range(99);
        op.idx    = ($urandom_range(99) < 85) ? IDX_IN_W'($urandom_range(cnt - 1))
                                              : IDX_IN_W'($urandom_range(7));
        op.period = LOAD_W'($urandom);
        op.delay  = LOAD_W'($urandom);
        if (r < 30)      op.kind = K_TICK;
        else if (r < 60) op.kind = K_POLL;
        else if (r < 68) op.kind = K_ENABLE;
        else if (r < 76) op.kind = K_DISABLE;
        else if (r < 92) op.kind = K_LOAD;
        else if (r < 95) op.kind = K_SPARE_A;
        else if (r < 98) op.kind = K_SPARE_B;
        else             op.kind = K_SPARE_C;
        if (op.kind == K_LOAD && $urandom_range(99) < 80) begin
            op.period = LOAD_W'($urandom_range(6));
            op.delay  = LOAD_W'($urandom_range(6));
        end
        return op;
    endfunction

    // Driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid    <= 1'b0;
            kind        <= '0;
            task_index  <= '0;
            load_period <= '0;
            load_delay  <= '0;
        end else begin
            if (in_valid && !in_stall)
                expected_runs.push_back(timer_step({kind, task_index, load_period, load_delay}));
            if (!in_valid || !in_stall) begin
                if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_op = pending_ops.pop_front();
                    kind        <= next_op.kind;
                    task_index  <= next_op.idx;
                    load_period <= next_op.period;
                    load_delay  <= next_op.delay;
                    in_valid    <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left = 0;
        end else if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1;
            stall_left = LONG_HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_runs.size() == 0) begin
                $error("unexpected result transaction");
                failures++;
            end else begin
                want = expected_runs.pop_front();
                if (run_valid !== want.run_valid) begin
                    $error("run_valid: expected %0d, actual %0d", want.run_valid, run_valid);
                    failures++;
                end
                if (run_task !== want.run_task) begin
                    $error("run_task: expected %0d, actual %0d", want.run_task, run_task);
                    failures++;
                end
                if (index_ignored !== want.ignored) begin
                    $error("index_ignored: expected %0d, actual %0d",
                           want.ignored, index_ignored);
                    failures++;
                end
            end
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        while (pending_ops.size() != 0 || in_valid || expected_runs.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_task_count(logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        pred_task_count = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    logic [CFG_W-1:0] cfg_plan [9] = '{3'd4, 3'd1, 3'd3, 3'd0, 3'd2, 3'd7, 3'd5, 3'd4, 3'd1};

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        out_stall = 1'b0;
        in_valid  = 1'b0;
        pred_task_count = TASK_COUNT_RST;
        pred_ptr = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
            pred_delay[i]  = '0;
            pred_period[i] = '0;
            pred_ready[i]  = 1'b1;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset table, extremes, disabled task, ignored indexes, spare kinds
        pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        pending_ops.push_back(make_op(K_LOAD, 0, LOAD_MAX, LOAD_MAX));
        pending_ops.push_back(make_op(K_LOAD, 1, 1, 0));
        pending_ops.push_back(make_op(K_LOAD, 3, 0, 2));
        pending_ops.push_back(make_op(K_DISABLE, 2, 0, 0));
        pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        pending_ops.push_back(make_op(K_TICK, 0, 0, 0));
        pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        pending_ops.push_back(make_op(K_ENABLE, 2, 0, 0));
        pending_ops.push_back(make_op(K_LOAD, 7, LOAD_MAX, LOAD_MAX));
        pending_ops.push_back(make_op(K_ENABLE, 4, 0, 0));
        pending_ops.push_back(make_op(K_DISABLE, 5, 0, 0));
        pending_ops.push_back(make_op(K_SPARE_A, 1, LOAD_MAX, 0));
        pending_ops.push_back(make_op(K_SPARE_B, 6, 0, LOAD_MAX));
        pending_ops.push_back(make_op(K_SPARE_C, 3, LOAD_MAX, LOAD_MAX));
        pending_ops.push_back(make_op(K_TICK, 0, 0, 0));
        pending_ops.push_back(make_op(K_TICK, 0, 0, 0));
        pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        wait_idle();

        // Park the pointer on the last task, then shrink the count below it
        for (int i = 0; i < ((3 - int'(pred_ptr)) & 3); i++)
            pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        wait_idle();
        write_task_count(3'd2);
        pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        pending_ops.push_back(make_op(K_LOAD, 2, 5, 5));
        pending_ops.push_back(make_op(K_POLL, 0, 0, 0));
        wait_idle();

        for (int seg = 0; seg < 9; seg++) begin
            write_task_count(cfg_plan[seg]);
            if (seg < 3) begin
                send_idle_pct = 7;
                recv_idle_pct = 72;
            end else if (seg < 6) begin
                send_idle_pct = 72;
                recv_idle_pct = 7;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 190; n++)
                pending_ops.push_back(random_op());
            if (seg == 7) long_hold_go = 1;
            wait_idle();
        end

        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
